/* hw/rtl/cma_pkg.sv */
// Shared types and constants for the cumulative average block.
// Used by cma_ctrl, cma_dp and cumulative_average_rounded.
package cma_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_ITEMS   = 65535;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned NumW    = SumW + 2;
  localparam int unsigned DenW    = CountW + 1;
  localparam int unsigned StepW   = $clog2(NumW);

  localparam logic [SampleW-1:0] SampleMask =
    SampleW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [CountW-1:0] MaxItems = CountW'(MAX_ITEMS);
  localparam logic [StepW-1:0]  LastStep = StepW'(NumW - 1);

  typedef enum logic [1:0] {
    StIdle,
    StAccum,
    StDiv,
    StResult
  } cma_state_e;

  typedef struct packed {
    logic load;
    logic accum;
    logic step;
    logic finish;
  } cma_cmd_t;

  typedef struct packed {
    logic full;
    logic div_last;
    logic out_blocked;
  } cma_sts_t;

endpackage

/* hw/rtl/cma_ctrl.sv */
// Sequencer for the cumulative average block: request intake, accumulate,
// divider steps and result handoff. Depends on cma_pkg.
module cma_ctrl import cma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cma_sts_t sts_i,
  output cma_cmd_t cmd_o
);

  cma_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StAccum;
      end
      StAccum: begin
        state_d = sts_i.full ? StResult : StDiv;
      end
      StDiv: begin
        if (sts_i.div_last) state_d = StResult;
      end
      StResult: begin
        if (!sts_i.out_blocked) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StAccum: begin
        cmd_o.accum = 1'b1;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
      end
      StResult: begin
        cmd_o.finish = !sts_i.out_blocked;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/cma_dp.sv */
// Datapath: running sum and count, restoring divider, output register.
// Depends on cma_pkg; driven by cma_ctrl commands.
module cma_dp import cma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cma_cmd_t           cmd_i,
  output cma_sts_t           sts_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        average_o,
  output logic               eos_o,
  output logic               ovf_o
);

  logic [SampleW-1:0] sample_q;
  logic               last_q;
  logic [SumW-1:0]    sum_q;
  logic [CountW-1:0]  count_q;
  logic [15:0]        last_avg_q;
  logic               ovf_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [StepW-1:0]   step_q;
  logic               out_valid_q;
  logic [15:0]        out_avg_q;
  logic               out_eos_q;
  logic               out_ovf_q;

  logic [SumW:0]      sum_ext;
  logic [SumW-1:0]    sum_new;
  logic [CountW-1:0]  count_new;
  logic [DenW:0]      rem_shift;
  logic [DenW:0]      rem_sub;
  logic               q_bit;
  logic [15:0]        quot_sat;
  logic [15:0]        avg_sel;

  assign sum_ext   = {1'b0, sum_q} + {{(SumW + 1 - SampleW){1'b0}}, sample_q};
  assign sum_new   = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
  assign count_new = count_q + CountW'(1);
  assign rem_shift = {rem_q, num_q[NumW-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign q_bit     = !rem_sub[DenW];
  assign quot_sat  = (|num_q[NumW-1:16]) ? 16'hFFFF : num_q[15:0];
  assign avg_sel   = ovf_q ? last_avg_q : quot_sat;

  assign sts_o.full        = (count_q >= MaxItems);
  assign sts_o.div_last    = (step_q == LastStep);
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      last_avg_q  <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (cmd_i.accum) begin
        step_q <= '0;
        if (!sts_o.full) begin
          sum_q   <= sum_new;
          count_q <= count_new;
        end
      end
      if (cmd_i.step) step_q <= step_q + StepW'(1);
      if (cmd_i.finish) begin
        last_avg_q <= avg_sel;
        if (last_q) begin
          sum_q   <= '0;
          count_q <= '0;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i & SampleMask;
      last_q   <= last_i;
    end
    if (cmd_i.accum) begin
      ovf_q <= sts_o.full;
      num_q <= {1'b0, sum_new, 1'b0} + {{(NumW - CountW){1'b0}}, count_new};
      den_q <= {count_new, 1'b0};
      rem_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= q_bit ? rem_sub[DenW-1:0] : rem_shift[DenW-1:0];
      num_q <= {num_q[NumW-2:0], q_bit};
    end
    if (cmd_i.finish) begin
      out_avg_q <= avg_sel;
      out_eos_q <= last_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign eos_o       = out_eos_q;
  assign ovf_o       = out_ovf_q;

endmodule

/* hw/rtl/cumulative_average_rounded.sv */
// Top level of the cumulative average block: cma_ctrl plus cma_dp.
// Depends on cma_pkg.
//
// Each input request carries one unsigned sample (tdata) and a last flag
// (tlast). Every request yields one result: the mean of all samples since
// the last restart, rounded half up, with tlast echoed and tuser set when
// the sample was dropped because the count had reached its maximum (the
// previous average is then repeated). A request is taken in the idle
// cycle; its result then passes the accumulate state, 34 steps of the
// one-bit-per-cycle restoring divider and the handoff state, and no new
// request is taken until its handoff is done. A dropped sample skips the
// divider. The output register holds a result while the next request
// is taken in; the handoff waits while an earlier result is still
// unaccepted.
module cumulative_average_rounded import cma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  input  logic        s_axis_tlast,  // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] average
  output logic        m_axis_tlast,  // end_of_sequence
  output logic        m_axis_tuser   // [0] overflow
);

  cma_cmd_t cmd;
  cma_sts_t sts;

  cma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .average_o   (m_axis_tdata),
    .eos_o       (m_axis_tlast),
    .ovf_o       (m_axis_tuser)
  );

endmodule

/* sim/cma_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for cumulative_average_rounded: watches both stream channels,
// predicts the rounded running mean of each request and compares results.
// Depends on cma_pkg.
module cma_checker import cma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [SampleW-1:0] s_tdata_i,
  input  logic               s_tlast_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [SampleW-1:0] m_tdata_i,
  input  logic               m_tlast_i,
  input  logic               m_tuser_i,
  input  logic               run_done_i,
  output int                 errors_o,
  output int                 results_seen_o
);

  typedef struct packed {
    logic [SampleW-1:0] average;
    logic               eos;
    logic               ovf;
  } avg_result_t;

  logic [SumW-1:0]    acc_sum;
  logic [CountW-1:0]  acc_count;
  logic [SampleW-1:0] held_average;
  avg_result_t        expected_avgs[$];
  avg_result_t        oldest;
  logic               leftover_checked;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors_o = errors_o + 1;
  endtask

  // Running mean, rounded half up: (2*sum + n) / (2*n).
  task automatic predict_average(input logic [SampleW-1:0] sample, input logic restart);
    logic [SumW:0] wide_sum;
    logic [63:0]   quot;
    avg_result_t   res;
    res.ovf = 1'b0;
    if (acc_count >= MaxItems) begin
      res.ovf = 1'b1;
    end else begin
      wide_sum = {1'b0, acc_sum} + {{(SumW + 1 - SampleW){1'b0}}, sample & SampleMask};
      if (wide_sum[SumW]) begin
        wide_sum = {1'b0, {SumW{1'b1}}};
      end
      acc_sum   = wide_sum[SumW-1:0];
      acc_count = acc_count + CountW'(1);
      quot = (64'(acc_sum) * 64'd2 + 64'(acc_count)) / (64'(acc_count) * 64'd2);
      held_average = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
    end
    res.average = held_average;
    res.eos     = restart;
    expected_avgs.push_back(res);
    if (restart) begin
      acc_sum   = '0;
      acc_count = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum          = '0;
      acc_count        = '0;
      held_average     = '0;
      errors_o         = 0;
      leftover_checked = 1'b0;
      expected_avgs.delete();
      results_seen_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predict_average(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_avgs.size() == 0) begin
          report_mismatch($sformatf("unexpected result, average %0d", m_tdata_i));
        end else begin
          oldest = expected_avgs.pop_front();
          if (m_tdata_i !== oldest.average) begin
            report_mismatch($sformatf("average got %0d expected %0d",
                                      m_tdata_i, oldest.average));
          end
          if (m_tlast_i !== oldest.eos) begin
            report_mismatch($sformatf("end_of_sequence got %b expected %b",
                                      m_tlast_i, oldest.eos));
          end
          if (m_tuser_i !== oldest.ovf) begin
            report_mismatch($sformatf("overflow got %b expected %b",
                                      m_tuser_i, oldest.ovf));
          end
        end
      end
      if (run_done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_avgs.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", expected_avgs.size()));
        end
      end
    end
  end

endmodule

/* sim/tb_cumulative_average_rounded.sv */
`timescale 1ns / 1ps
// Testbench top for cumulative_average_rounded: clock, reset, request
// stimulus with random gaps and stalls, and the verdict.
// Depends on cma_pkg, cma_checker and the RTL.
module tb_cumulative_average_rounded;
  import cma_pkg::*;

  localparam int unsigned CycleLimit  = 12_000_000;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned DrainCycles = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [SampleW-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  int   errors;
  int   results_seen;
  int   items_sent;
  int   cycle_count;
  logic tx_idle;
  logic rx_idle;
  logic run_done;

  cumulative_average_rounded uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  cma_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tlast_i      (s_axis_tlast),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tlast_i      (m_axis_tlast),
    .m_tuser_i      (m_axis_tuser),
    .run_done_i     (run_done),
    .errors_o       (errors),
    .results_seen_o (results_seen)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall before each result while rx_idle is set
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = rx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_request(input logic [SampleW-1:0] smp, input logic lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_seen != items_sent);
  endtask

  function automatic logic [SampleW-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SampleW'($urandom_range(0, 3));
      3: return SampleW'($urandom_range(65532, 65535));
      default: return SampleW'($urandom());
    endcase
  endfunction

  initial begin
    int                 seq_len;
    int                 random_sent;
    int                 seq_idx;
    logic [SampleW-1:0] base;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    run_done      = 1'b0;
    items_sent    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and half-up rounding
    send_request(16'd0, 1'b1);
    send_request(16'hFFFF, 1'b1);
    send_request(16'd0, 1'b0);
    send_request(16'd1, 1'b1);
    send_request(16'd1, 1'b0);
    send_request(16'd2, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFE, 1'b1);
    send_request(16'd1, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b1);
    send_request(16'd2, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b1);
    send_request(16'h8000, 1'b0);
    send_request(16'h7FFF, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);
    drain_results();

    random_sent = 0;
    seq_idx     = 0;
    while (random_sent < RandomItems) begin
      if (seq_idx % 8 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 11) == 0) begin
        drain_results();
      end
      seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
      base    = draw_sample();
      for (int i = 0; i < seq_len; i++) begin
        send_request(($urandom_range(0, 2) == 0) ? base + SampleW'($urandom_range(0, 1))
                                                  : draw_sample(),
                     i == seq_len - 1);
        random_sent++;
      end
      seq_idx++;
    end
    s_axis_tvalid <= 1'b0;

    while (results_seen != items_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    run_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
